// File: src/sbc_pkg.sv
// sbc_pkg: shared types, constants and the arctangent table of the scan clusterer
// no dependencies
`timescale 1ns / 1ps

package sbc_pkg;

  localparam int MAX_SAMPLES_DEF   = 4096;
  localparam int TRIG_FRAC_DEF     = 16;
  localparam int CORDIC_STEPS      = 24;
  localparam int CNT_W             = 5;
  localparam int CX_W              = 34;
  localparam int CZ_W              = 32;
  localparam int COORD_W           = 17;
  localparam int COORD_LIMIT       = 65535;
  localparam int ID_W              = 12;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_W             = 16;

  localparam logic signed [CX_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_FLOOR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_CEILING  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_DISTANCE = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ANGLE,
    S_START,
    S_ROT,
    S_PROJ_X,
    S_PROJ_Y,
    S_DIFF_X,
    S_DIFF_Y,
    S_LIMIT,
    S_UPDATE,
    S_EMIT,
    S_FLUSH,
    S_EMIT_LAST
  } state_t;

  // arctangent of 2^-i in 32-bit binary angle units
  function automatic logic signed [CZ_W-1:0] atan_at(input logic [CNT_W-1:0] i);
    logic signed [CZ_W-1:0] v;
    case (i)
      5'd0:  v = 32'sd536870912;
      5'd1:  v = 32'sd316933406;
      5'd2:  v = 32'sd167458907;
      5'd3:  v = 32'sd85004756;
      5'd4:  v = 32'sd42667331;
      5'd5:  v = 32'sd21354465;
      5'd6:  v = 32'sd10679838;
      5'd7:  v = 32'sd5340245;
      5'd8:  v = 32'sd2670163;
      5'd9:  v = 32'sd1335087;
      5'd10: v = 32'sd667544;
      5'd11: v = 32'sd333772;
      5'd12: v = 32'sd166886;
      5'd13: v = 32'sd83443;
      5'd14: v = 32'sd41722;
      5'd15: v = 32'sd20861;
      5'd16: v = 32'sd10430;
      5'd17: v = 32'sd5215;
      5'd18: v = 32'sd2608;
      5'd19: v = 32'sd1304;
      5'd20: v = 32'sd652;
      5'd21: v = 32'sd326;
      5'd22: v = 32'sd163;
      5'd23: v = 32'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: src/sbc_cordic.sv
// sbc_cordic: iterative rotation-mode cordic, one step a cycle, with quadrant fold
// depends on sbc_pkg
`timescale 1ns / 1ps

module sbc_cordic import sbc_pkg::*; #(
  parameter int TRIG_FRACTION_BITS = TRIG_FRAC_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start_i,
  input  logic [15:0]                        angle_i,
  output logic                               busy_o,
  output logic signed [TRIG_FRACTION_BITS+1:0] cos_o,
  output logic signed [TRIG_FRACTION_BITS+1:0] sin_o
);

  localparam int TW = TRIG_FRACTION_BITS + 2;
  localparam int SH = 30 - TRIG_FRACTION_BITS;

  logic signed [CX_W-1:0] x_r, y_r, x_nxt, y_nxt, dx, dy;
  logic signed [CZ_W-1:0] z_r, z_nxt;
  logic [CNT_W-1:0]       cnt_r;
  logic                   busy_r;
  logic [1:0]             quad_r;
  logic signed [TW-1:0]   cq, sq;

  always_comb begin
    dx = y_r >>> cnt_r;
    dy = x_r >>> cnt_r;
    if (!z_r[CZ_W-1]) begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      z_nxt = z_r - atan_at(cnt_r);
    end else begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      z_nxt = z_r + atan_at(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      x_r    <= CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= $signed({2'b00, angle_i[13:0], 16'h0000});
      quad_r <= angle_i[15:14];
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign cq = TW'(x_r >>> SH);
  assign sq = TW'(y_r >>> SH);

  always_comb begin
    case (quad_r)
      2'd0: begin cos_o = cq;  sin_o = sq;  end
      2'd1: begin cos_o = -sq; sin_o = cq;  end
      2'd2: begin cos_o = -cq; sin_o = -sq; end
      default: begin cos_o = sq; sin_o = -cq; end
    endcase
  end

  assign busy_o = busy_r;

endmodule

// File: src/scan_breakpoint_clusterer.sv
// scan_breakpoint_clusterer: splits a laser scan into clusters and reports bounding boxes
// depends on sbc_pkg and sbc_cordic
//
//  channel | ports                               | handshake
//  --------+-------------------------------------+---------------------
//  in      | in_range_mm, in_scan_end            | in_valid / in_ready
//  out     | out_cluster_id .. out_scan_done     | out_valid / out_ready
//  cfg     | cfg_index, cfg_wdata                | cfg_we, no wait
//
// a sample in range passes through the 24 cordic steps and through
// one shared multiplier used six times in turn; a sample out of range skips both
// one sample at a time: in_ready is low until its results have gone out
// up to two result beats per sample, each held until out_ready
// synchronous active-low reset, no clearing pass
`timescale 1ns / 1ps

module scan_breakpoint_clusterer import sbc_pkg::*; #(
  parameter int MAX_SAMPLES        = MAX_SAMPLES_DEF,
  parameter int TRIG_FRACTION_BITS = TRIG_FRAC_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [15:0]               in_range_mm,
  input  logic                      in_scan_end,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ID_W-1:0]           out_cluster_id,
  output logic signed [COORD_W-1:0] out_center_x,
  output logic signed [COORD_W-1:0] out_center_y,
  output logic [COORD_W-1:0]        out_box_width,
  output logic [COORD_W-1:0]        out_box_height,
  output logic                      out_scan_done,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_SAMPLES);
  localparam int TW    = TRIG_FRACTION_BITS + 2;
  localparam int MB    = (TW > 18) ? TW : 18;
  localparam int PW    = 18 + MB;
  localparam logic signed [PW:0] HALF  = (PW+1)'(2 ** (TRIG_FRACTION_BITS - 1));
  localparam logic signed [PW:0] LIM_P = (PW+1)'(COORD_LIMIT);
  localparam logic signed [PW:0] LIM_N = -LIM_P;

  state_t state_r, state_nxt;

  logic [15:0] floor_r, ceil_r, start_r, step_r, bd_r;
  logic [15:0] range_r;
  logic        last_r;
  logic [IDX_W-1:0] idx_r;
  logic [ID_W-1:0]  cnum_r;
  logic        open_r;
  logic signed [COORD_W-1:0] x_r, y_r, last_x_r, last_y_r;
  logic signed [COORD_W-1:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic signed [PW-1:0] prod_r;
  logic signed [PW:0]   sq_r, sum_r;

  logic signed [17:0]   mul_a, dx, dy;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW:0]   rnd, shf;
  logic signed [COORD_W-1:0] proj;
  logic        near;

  logic                 cor_start, cor_busy;
  logic signed [TW-1:0] cor_cos, cor_sin;

  logic [COORD_W-1:0]        res_w, res_h;
  logic signed [COORD_W-1:0] res_cx, res_cy;
  logic        load_out, load_done;

  logic [ID_W-1:0]           oid_r;
  logic signed [COORD_W-1:0] ocx_r, ocy_r;
  logic [COORD_W-1:0]        ow_r, oh_r;
  logic                      odone_r;

  sbc_cordic #(.TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cor_start),
    .angle_i (start_r + prod_r[15:0]),
    .busy_o  (cor_busy),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= 16'd0;
      ceil_r  <= 16'hFFFF;
      start_r <= 16'h8000;
      step_r  <= 16'd16;
      bd_r    <= 16'd300;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE_FLOOR:    floor_r <= cfg_wdata;
        REG_RANGE_CEILING:  ceil_r  <= cfg_wdata;
        REG_START_ANGLE:    start_r <= cfg_wdata;
        REG_ANGLE_STEP:     step_r  <= cfg_wdata;
        REG_BREAK_DISTANCE: bd_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign dx = 18'(x_r) - 18'(last_x_r);
  assign dy = 18'(y_r) - 18'(last_y_r);

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      S_ANGLE:  begin mul_a = $signed(18'(idx_r));   mul_b = $signed(MB'(step_r)); end
      S_PROJ_X: begin mul_a = $signed(18'(range_r)); mul_b = MB'(cor_cos);         end
      S_PROJ_Y: begin mul_a = $signed(18'(range_r)); mul_b = MB'(cor_sin);         end
      S_DIFF_X: begin mul_a = dx;                    mul_b = MB'(dx);              end
      S_DIFF_Y: begin mul_a = dy;                    mul_b = MB'(dy);              end
      S_LIMIT:  begin mul_a = $signed(18'(bd_r));    mul_b = $signed(MB'(bd_r));   end
      default:  begin mul_a = '0;                    mul_b = '0;                   end
    endcase
  end

  assign prod = mul_a * mul_b;

  // round to millimetres and clamp
  always_comb begin
    rnd = $signed({prod_r[PW-1], prod_r}) + HALF;
    shf = rnd >>> TRIG_FRACTION_BITS;
    if (shf > LIM_P)      proj = COORD_W'(LIM_P);
    else if (shf < LIM_N) proj = COORD_W'(LIM_N);
    else                  proj = COORD_W'(shf);
  end

  assign near = (sum_r <= $signed({prod_r[PW-1], prod_r}));

  assign res_w  = COORD_W'(max_x_r - min_x_r);
  assign res_h  = COORD_W'(max_y_r - min_y_r);
  assign res_cx = min_x_r + $signed({1'b0, res_w[COORD_W-1:1]});
  assign res_cy = min_y_r + $signed({1'b0, res_h[COORD_W-1:1]});

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (floor_r <= in_range_mm && in_range_mm <= ceil_r) state_nxt = S_ANGLE;
          else state_nxt = S_FLUSH;
        end
      end
      S_ANGLE:  state_nxt = S_START;
      S_START:  state_nxt = S_ROT;
      S_ROT:    if (!cor_busy) state_nxt = S_PROJ_X;
      S_PROJ_X: state_nxt = S_PROJ_Y;
      S_PROJ_Y: state_nxt = S_DIFF_X;
      S_DIFF_X: state_nxt = S_DIFF_Y;
      S_DIFF_Y: state_nxt = S_LIMIT;
      S_LIMIT:  state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = (open_r && !near) ? S_EMIT : S_FLUSH;
      S_EMIT:   if (out_ready) state_nxt = S_FLUSH;
      S_FLUSH:  state_nxt = (last_r && open_r) ? S_EMIT_LAST : S_IDLE;
      S_EMIT_LAST: if (out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    out_valid = (state_r == S_EMIT) || (state_r == S_EMIT_LAST);
    cor_start = (state_r == S_START);
    load_out  = 1'b0;
    load_done = 1'b0;
    case (state_r)
      S_UPDATE: load_out = open_r && !near;
      S_FLUSH: begin
        load_out  = last_r && open_r;
        load_done = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      cnum_r   <= '0;
      open_r   <= 1'b0;
      last_x_r <= '0;
      last_y_r <= '0;
      min_x_r  <= '0;
      max_x_r  <= '0;
      min_y_r  <= '0;
      max_y_r  <= '0;
    end else begin
      case (state_r)
        S_UPDATE: begin
          if (open_r && near) begin
            if (x_r < min_x_r) min_x_r <= x_r;
            if (x_r > max_x_r) max_x_r <= x_r;
            if (y_r < min_y_r) min_y_r <= y_r;
            if (y_r > max_y_r) max_y_r <= y_r;
          end else begin
            // the breaking point, or the first sample when none is open, opens a new cluster
            if (open_r) cnum_r <= cnum_r + 1'b1;
            min_x_r <= x_r;
            max_x_r <= x_r;
            min_y_r <= y_r;
            max_y_r <= y_r;
            open_r  <= 1'b1;
          end
          last_x_r <= x_r;
          last_y_r <= y_r;
        end
        S_FLUSH: begin
          if (last_r) begin
            idx_r  <= '0;
            cnum_r <= '0;
            open_r <= 1'b0;
          end else if (idx_r == IDX_W'(MAX_SAMPLES - 1)) begin
            idx_r <= '0;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      range_r <= in_range_mm;
      last_r  <= in_scan_end;
    end
    prod_r <= prod;
    case (state_r)
      S_PROJ_Y: x_r  <= proj;
      S_DIFF_X: y_r  <= proj;
      S_DIFF_Y: sq_r <= $signed({prod_r[PW-1], prod_r});
      S_LIMIT:  sum_r <= sq_r + $signed({prod_r[PW-1], prod_r});
      default: ;
    endcase
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (load_out) begin
      oid_r   <= cnum_r;
      ocx_r   <= res_cx;
      ocy_r   <= res_cy;
      ow_r    <= res_w;
      oh_r    <= res_h;
      odone_r <= load_done;
    end
  end

  assign out_cluster_id = oid_r;
  assign out_center_x   = ocx_r;
  assign out_center_y   = ocy_r;
  assign out_box_width  = ow_r;
  assign out_box_height = oh_r;
  assign out_scan_done  = odone_r;

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input taken while a result beat waits");

  a_scan_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_scan_done) |=> (idx_r == '0 && !open_r && cnum_r == '0))
    else $error("scan state not cleared after final beat");

  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> (min_x_r <= max_x_r && min_y_r <= max_y_r))
    else $error("bounding box inverted");

  a_rot_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_START) |=> cor_busy)
    else $error("rotation unit did not start");

endmodule

// File: tb/testbench.sv
// testbench: self-checking bench for scan_breakpoint_clusterer with a cluster-box scoreboard
// depends on sbc_pkg and the scan_breakpoint_clusterer rtl
`timescale 1ns / 1ps

module testbench;
  import sbc_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int SCAN_SAMPLES = 4096;

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [COORD_W-1:0]        w;
    logic [COORD_W-1:0]        h;
    logic                      done;
  } box_beat_t;

  class cluster_board;
    longint floor_mm, ceil_mm, start_ang, step_ang, brk;
    longint sample_idx, cluster_no;
    bit     open;
    longint lx, ly, mnx, mxx, mny, mxy;
    box_beat_t pending[$];
    int errors;

    function void clear();
      floor_mm = 0; ceil_mm = 65535; start_ang = 32768; step_ang = 16; brk = 300;
      sample_idx = 0; cluster_no = 0; open = 0;
      lx = 0; ly = 0; mnx = 0; mxx = 0; mny = 0; mxy = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
      case (idx)
        REG_RANGE_FLOOR:    floor_mm = longint'(v);
        REG_RANGE_CEILING:  ceil_mm = longint'(v);
        REG_START_ANGLE:    start_ang = longint'(v);
        REG_ANGLE_STEP:     step_ang = longint'(v);
        REG_BREAK_DISTANCE: brk = longint'(v);
        default: ;
      endcase
    endfunction

    // >>> on longint is an arithmetic floor shift
    function longint sat_proj(longint r, longint t);
      longint v;
      v = (r * t + (64'sd1 <<< 15)) >>> 16;
      if (v > 65535) v = 65535;
      if (v < -65535) v = -65535;
      return v;
    endfunction

    function void sin_cos(longint ang, output longint c, output longint s);
      longint x, y, z, dx, dy, cq, sq;
      x = 652032874; y = 0; z = (ang & 16'h3fff) << 16;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i; dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(atan_at(i[4:0]));
        end else begin
          x += dx; y -= dy; z += longint'(atan_at(i[4:0]));
        end
      end
      cq = x >>> 14; sq = y >>> 14;
      case ((ang >> 14) & 3)
        0: begin c = cq; s = sq; end
        1: begin c = -sq; s = cq; end
        2: begin c = -cq; s = -sq; end
        default: begin c = sq; s = -cq; end
      endcase
    endfunction

    function void push_box(bit done);
      box_beat_t b;
      longint w, h;
      w = mxx - mnx; h = mxy - mny;
      b.id = cluster_no[ID_W-1:0];
      b.cx = COORD_W'(mnx + (w >> 1));
      b.cy = COORD_W'(mny + (h >> 1));
      b.w = COORD_W'(w); b.h = COORD_W'(h); b.done = done;
      pending = {pending, b};
    endfunction

    function void note_sample(logic [15:0] range, logic last);
      longint ang, c, s, x, y, dx, dy;
      if (floor_mm <= range && range <= ceil_mm) begin
        ang = (start_ang + sample_idx * step_ang) & 16'hffff;
        sin_cos(ang, c, s);
        x = sat_proj(longint'(range), c); y = sat_proj(longint'(range), s);
        if (open) begin
          dx = x - lx; dy = y - ly;
          if (dx * dx + dy * dy <= brk * brk) begin
            if (x < mnx) mnx = x;
            if (x > mxx) mxx = x;
            if (y < mny) mny = y;
            if (y > mxy) mxy = y;
          end else begin
            push_box(0);
            cluster_no = (cluster_no + 1) & 12'hfff;
            mnx = x; mxx = x; mny = y; mxy = y;
          end
        end else begin
          mnx = x; mxx = x; mny = y; mxy = y; open = 1;
        end
        lx = x; ly = y;
      end
      sample_idx = (sample_idx + 1) % SCAN_SAMPLES;
      if (last) begin
        if (open) push_box(1);
        sample_idx = 0; cluster_no = 0; open = 0;
      end
    endfunction

    function void check_box(box_beat_t got);
      box_beat_t exp_b;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", got);
        return;
      end
      exp_b = pending.pop_front();
      if (got !== exp_b) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected id %0d cx %0d cy %0d w %0d h %0d done %0d, got id %0d cx %0d cy %0d w %0d h %0d done %0d",
                   exp_b.id, exp_b.cx, exp_b.cy, exp_b.w, exp_b.h, exp_b.done,
                   got.id, got.cx, got.cy, got.w, got.h, got.done);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_ready;
  logic [15:0] in_range_mm = '0;
  logic in_scan_end = 0;
  logic out_valid, out_ready = 0;
  logic [ID_W-1:0] out_cluster_id;
  logic signed [COORD_W-1:0] out_center_x, out_center_y;
  logic [COORD_W-1:0] out_box_width, out_box_height;
  logic out_scan_done;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  cluster_board board;
  int cycle_count = 0;
  int send_idle_pct = 0, stall_pct = 0;

  always #4 clk = ~clk;

  scan_breakpoint_clusterer dut (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: check accepted beats, then stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_box({out_cluster_id, out_center_x, out_center_y,
                       out_box_width, out_box_height, out_scan_done});
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    board.set_reg(idx, v);
    @(posedge clk);
  endtask

  // valid stays high into the next beat when there is no idle gap
  task automatic send_sample(logic [15:0] range, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; in_range_mm <= range; in_scan_end <= last;
    do @(posedge clk); while (!in_ready);
    board.note_sample(range, last);
  endtask

  // results drain, then allow for a sample still in flight
  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_all(logic [15:0] fl, logic [15:0] ce, logic [15:0] sa,
                         logic [15:0] st, logic [15:0] bd);
    drain();
    write_reg(REG_RANGE_FLOOR, fl);
    write_reg(REG_RANGE_CEILING, ce);
    write_reg(REG_START_ANGLE, sa);
    write_reg(REG_ANGLE_STEP, st);
    write_reg(REG_BREAK_DISTANCE, bd);
  endtask

  // mostly smooth ranges with occasional jumps so clusters form and break
  task automatic random_scan(int n, int jump_pct);
    logic [15:0] r;
    r = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < jump_pct) r = 16'($urandom);
      else r = r + 16'($urandom_range(200)) - 16'd100;
      send_sample(r, i == n - 1);
    end
  endtask

  initial begin
    int sent;
    board = new();
    board.clear();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, ignored samples, break on the final sample
    send_sample(16'd0, 0);
    send_sample(16'hffff, 0);
    send_sample(16'd1000, 0);
    send_sample(16'd1010, 0);
    send_sample(16'd5000, 1);
    send_sample(16'd40000, 1);
    drain();
    write_reg(REG_RANGE_FLOOR, 16'd100);
    write_reg(REG_RANGE_CEILING, 16'd50);
    send_sample(16'd70, 0);
    send_sample(16'd70, 1);
    set_all(16'd0, 16'hffff, 16'h7fff, 16'hffff, 16'hffff);
    send_sample(16'hffff, 0);
    send_sample(16'hffff, 0);
    send_sample(16'd1, 1);
    set_all(16'd0, 16'hffff, 16'h0000, 16'h4000, 16'd0);
    for (int i = 0; i < 6; i++) send_sample(16'd3000, i == 5);

    sent = 0;
    for (int ph = 0; sent < 1950; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 75; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      if (ph % 3 == 2)
        set_all(16'($urandom_range(2000)), 16'hffff - 16'($urandom_range(2000)),
                16'($urandom), 16'($urandom_range(400)), 16'($urandom));
      else
        set_all(16'($urandom_range(500)), 16'($urandom_range(65535, 20000)),
                16'($urandom), 16'($urandom_range(64)), 16'($urandom_range(1500)));
      for (int k = 0; k < 8; k++) begin
        int n;
        n = $urandom_range(40, 1);
        random_scan(n, $urandom_range(30));
        sent += n;
      end
      if (ph == 5) drain();
    end

    drain();
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
